### hdl/text_console_glyph_renderer_unit_macros.svh
// assertion macros for the text console glyph renderer
// used by files that check their own sequencing; expects clk and rst_n in scope
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_UNIT_MACROS_SVH

// same-cycle implication
`define TCGR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCGR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/tcgr_pkg.sv
// shared types and codes for the text console glyph renderer
// no dependencies
package tcgr_pkg;

  localparam int STORE_AW = 12;
  localparam int MOD_W    = 10;

  // input word kinds
  localparam logic [1:0] KIND_CHAR   = 2'd0;
  localparam logic [1:0] KIND_GLYPH  = 2'd1;
  localparam logic [1:0] KIND_CURSOR = 2'd2;

  // result actions
  localparam logic [1:0] ACT_STATUS = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_SCROLL = 2'd2;

  // register indexes
  localparam logic [2:0] REG_PITCH   = 3'd0;
  localparam logic [2:0] REG_COLUMNS = 3'd1;
  localparam logic [2:0] REG_ROWS    = 3'd2;
  localparam logic [2:0] REG_PAL_LO  = 3'd3;
  localparam logic [2:0] REG_PAL_HI  = 3'd4;

  localparam logic [7:0] CHAR_NL = 8'd10;
  localparam logic [7:0] CHAR_CR = 8'd13;

  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] dividend;
    logic [MOD_W-1:0] divisor;
  } mod_ctl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MOD_W-1:0] rem;
  } mod_sts_t;

endpackage

### hdl/text_console_glyph_renderer_unit.sv
// text console glyph renderer, top level: sequencer, cursor, config registers
// uses tcgr_pkg, tcgr_glyph_mem, tcgr_mod_unit and the assertion macro header
//
// Renders text into an 8-bit palettized framebuffer and tracks a character
// cursor. One input word is taken at a time and in_stall stays high until its
// last result has been produced. A printable character goes through setup
// (accept, row-times-pitch multiply, base address and cursor update) and
// then emits GLYPH_HEIGHT result words, one per glyph row, plus one scroll
// word when the cursor runs off the last line; the glyph store read port
// feeds one row per cycle while the output side does not stall. Set cursor
// runs two remainders through the shared bit-serial unit, one bit per cycle.
// Every result carries the cursor as it stands after the whole word; last
// marks the final result of a word. The glyph store is not cleared: reading
// a glyph entry that was never loaded gives an unspecified pattern.
// Registers are to be written only while the block is idle; the block
// itself does not enforce this. cfg_ready is always high.
`include "text_console_glyph_renderer_unit_macros.svh"

module text_console_glyph_renderer_unit #(
  parameter int GLYPH_WIDTH  = 8,
  parameter int GLYPH_HEIGHT = 16,
  parameter int GLYPH_COUNT  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_char_code,
  input  logic [3:0]  in_fore_index,
  input  logic [3:0]  in_back_index,
  input  logic [11:0] in_glyph_addr,
  input  logic [7:0]  in_glyph_byte,
  input  logic [9:0]  in_new_col,
  input  logic [9:0]  in_new_row,
  // result words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [20:0] out_pixel_addr,
  output logic [63:0] out_pixel_bytes,
  output logic [8:0]  out_cursor_col,
  output logic [6:0]  out_cursor_row,
  output logic        out_last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import tcgr_pkg::*;

  localparam int RW = $clog2(GLYPH_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE, S_STATUS, S_MODC, S_MODR, S_MUL, S_BASE, S_ROWS, S_SCROLL
  } state_t;

  state_t state_r;

  // config registers
  logic [11:0] pitch_r;
  logic [8:0]  columns_r;
  logic [6:0]  rows_r;
  logic [63:0] pal_lo_r;
  logic [63:0] pal_hi_r;

  // cursor and per-word working registers
  logic [8:0]          cursor_col_r;
  logic [6:0]          cursor_row_r;
  logic [7:0]          fg_r;
  logic [7:0]          bg_r;
  logic [STORE_AW-1:0] gbase_r;
  logic [9:0]          new_row_r;
  logic [20:0]         prod_r;
  logic [20:0]         addr_r;
  logic [RW-1:0]       row_i_r;
  logic                scroll_r;
  logic [1:0]          action_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_action_r;
  logic [20:0] out_addr_r;
  logic [63:0] out_bytes_r;
  logic [8:0]  out_col_r;
  logic [6:0]  out_row_r;
  logic        out_last_r;

  logic accept;
  logic emit_ok;
  logic emit_row;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign emit_ok   = !out_valid_r || !out_stall;
  assign emit_row  = (state_r == S_ROWS) && emit_ok;

  // zero columns or rows count as one for wrap and scroll
  logic [8:0] cols_eff;
  logic [6:0] rows_eff;
  assign cols_eff = (columns_r == '0) ? 9'd1 : columns_r;
  assign rows_eff = (rows_r == '0) ? 7'd1 : rows_r;

  // palette lookup for the accepted word
  logic [63:0] fg_word;
  logic [63:0] bg_word;
  logic [7:0]  fg_col;
  logic [7:0]  bg_col;
  always_comb begin
    fg_word = in_fore_index[3] ? pal_hi_r : pal_lo_r;
    bg_word = in_back_index[3] ? pal_hi_r : pal_lo_r;
    fg_col  = fg_word[{in_fore_index[2:0], 3'b000} +: 8];
    bg_col  = bg_word[{in_back_index[2:0], 3'b000} +: 8];
  end

  // glyph base address: (code, less count once if code >= count) * height, wrapped to the store
  logic [7:0]  code_red;
  logic [12:0] gbase_full;
  always_comb begin
    code_red   = ({1'b0, in_char_code} >= 9'(GLYPH_COUNT)) ?
                 8'({1'b0, in_char_code} - 9'(GLYPH_COUNT)) : in_char_code;
    gbase_full = {5'b0, code_red} * 13'(GLYPH_HEIGHT);
  end

  // cursor after newline and after a drawn character
  logic [6:0] nl_row;
  logic       nl_scroll;
  logic [8:0] ch_col;
  logic [6:0] ch_row;
  logic [6:0] ch_row_clamped;
  logic       ch_scroll;
  always_comb begin
    nl_row    = cursor_row_r + 7'd1;
    nl_scroll = (nl_row >= rows_eff);
    if (nl_scroll) begin
      nl_row = rows_eff - 7'd1;
    end
    ch_col = cursor_col_r + 9'd1;
    ch_row = cursor_row_r;
    if (ch_col >= cols_eff) begin
      ch_col = '0;
      ch_row = cursor_row_r + 7'd1;
    end
    ch_scroll      = (ch_row >= rows_eff);
    ch_row_clamped = ch_scroll ? (rows_eff - 7'd1) : ch_row;
  end

  // pixel row address arithmetic
  logic [11:0] px_row;
  logic [11:0] px_col;
  logic [23:0] row_prod;
  always_comb begin
    px_row   = 12'({5'b0, cursor_row_r} * 12'(GLYPH_HEIGHT));
    px_col   = 12'({3'b0, cursor_col_r} * 12'(GLYPH_WIDTH));
    row_prod = {12'b0, px_row} * {12'b0, pitch_r};
  end

  // glyph store: read address runs one row ahead while a row is emitted
  logic                glyph_we;
  logic [STORE_AW-1:0] glyph_raddr;
  logic [7:0]          glyph_rdata;
  assign glyph_we    = accept && (in_kind == KIND_GLYPH);
  assign glyph_raddr = gbase_r + STORE_AW'(row_i_r) + STORE_AW'(emit_row);

  tcgr_glyph_mem u_glyph_mem (
    .clk   (clk),
    .we    (glyph_we),
    .waddr (in_glyph_addr),
    .wdata (in_glyph_byte),
    .raddr (glyph_raddr),
    .rdata (glyph_rdata)
  );

  // expand one glyph row into eight palette bytes
  logic [63:0] packed_row;
  always_comb begin
    packed_row = '0;
    for (int j = 0; j < 8; j++) begin
      if (j < GLYPH_WIDTH) begin
        packed_row[j*8 +: 8] = glyph_rdata[j] ? fg_r : bg_r;
      end
    end
  end

  // shared remainder unit for set cursor
  mod_ctl_t mod_ctl;
  mod_sts_t mod_sts;
  always_comb begin
    mod_ctl.start    = (accept && (in_kind == KIND_CURSOR)) ||
                       ((state_r == S_MODC) && mod_sts.done);
    mod_ctl.dividend = (state_r == S_IDLE) ? in_new_col : new_row_r;
    mod_ctl.divisor  = (state_r == S_IDLE) ? (10'(columns_r) + 10'd1)
                                           : (10'(rows_r) + 10'd1);
  end

  tcgr_mod_unit u_mod_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mod_ctl),
    .sts   (mod_sts)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pitch_r   <= 12'd800;
      columns_r <= 9'd100;
      rows_r    <= 7'd30;
      pal_lo_r  <= 64'h0706050403020100;
      pal_hi_r  <= 64'h0F0E0D0C0B0A0908;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PITCH:   pitch_r   <= cfg_data[11:0];
        REG_COLUMNS: columns_r <= cfg_data[8:0];
        REG_ROWS:    rows_r    <= cfg_data[6:0];
        REG_PAL_LO:  pal_lo_r  <= cfg_data;
        REG_PAL_HI:  pal_hi_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer, cursor and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cursor_col_r <= '0;
      cursor_row_r <= '0;
      out_valid_r  <= 1'b0;
      row_i_r      <= '0;
      scroll_r     <= 1'b0;
      action_r     <= ACT_STATUS;
    end else begin
      // emitting states load a new word, the others let the register drain
      if (emit_ok && !(state_r inside {S_ROWS, S_SCROLL, S_STATUS})) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            fg_r      <= fg_col;
            bg_r      <= bg_col;
            gbase_r   <= gbase_full[STORE_AW-1:0];
            new_row_r <= in_new_row;
            action_r  <= ((in_kind == KIND_CHAR) && (in_char_code == CHAR_NL) && nl_scroll) ?
                         ACT_SCROLL : ACT_STATUS;
            case (in_kind)
              KIND_CHAR: begin
                if (in_char_code == CHAR_NL) begin
                  cursor_col_r <= '0;
                  cursor_row_r <= nl_row;
                  state_r      <= S_STATUS;
                end else if (in_char_code == CHAR_CR) begin
                  cursor_col_r <= '0;
                  state_r      <= S_STATUS;
                end else begin
                  state_r <= S_MUL;
                end
              end
              KIND_CURSOR: state_r <= S_MODC;
              default:     state_r <= S_STATUS;
            endcase
          end
        end
        S_MODC: begin
          if (mod_sts.done) begin
            cursor_col_r <= mod_sts.rem[8:0];
            state_r      <= S_MODR;
          end
        end
        S_MODR: begin
          if (mod_sts.done) begin
            cursor_row_r <= mod_sts.rem[6:0];
            state_r      <= S_STATUS;
          end
        end
        S_MUL: begin
          prod_r  <= row_prod[20:0];
          state_r <= S_BASE;
        end
        S_BASE: begin
          // glyph row 0 is read this cycle; cursor moves past the cell
          addr_r       <= prod_r + 21'(px_col);
          row_i_r      <= '0;
          cursor_col_r <= ch_col;
          cursor_row_r <= ch_row_clamped;
          scroll_r     <= ch_scroll;
          state_r      <= S_ROWS;
        end
        S_ROWS: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_action_r <= ACT_WRITE;
            out_addr_r   <= addr_r;
            out_bytes_r  <= packed_row;
            out_col_r    <= cursor_col_r;
            out_row_r    <= cursor_row_r;
            out_last_r   <= (row_i_r == RW'(GLYPH_HEIGHT - 1)) && !scroll_r;
            addr_r       <= addr_r + {9'b0, pitch_r};
            // row counter back to zero so the next glyph starts at its row 0
            if (row_i_r == RW'(GLYPH_HEIGHT - 1)) begin
              row_i_r <= '0;
              state_r <= scroll_r ? S_SCROLL : S_IDLE;
            end else begin
              row_i_r <= row_i_r + 1'b1;
            end
          end
        end
        S_SCROLL, S_STATUS: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_action_r <= (state_r == S_SCROLL) ? ACT_SCROLL : action_r;
            out_addr_r   <= '0;
            out_bytes_r  <= '0;
            out_col_r    <= cursor_col_r;
            out_row_r    <= cursor_row_r;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_pixel_addr  = out_addr_r;
  assign out_pixel_bytes = out_bytes_r;
  assign out_cursor_col  = out_col_r;
  assign out_cursor_row  = out_row_r;
  assign out_last        = out_last_r;

  // an accepted word always leaves idle
  `TCGR_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "word accepted but block stayed idle")
  // the remainder unit only finishes while the sequencer waits for it
  `TCGR_ASSERT_NOW(a_mod_done_waited, mod_sts.done, (state_r == S_MODC) || (state_r == S_MODR), "remainder finished outside a wait state")
  // a scroll request always leaves the cursor on the last text line
  `TCGR_ASSERT_NOW(a_scroll_row_clamped, state_r == S_SCROLL, cursor_row_r == rows_eff - 7'd1, "scroll with cursor off the last line")
  // while rows are drawn the cursor is already inside the text area
  `TCGR_ASSERT_NOW(a_rows_cursor_inside, state_r == S_ROWS, cursor_row_r < rows_eff, "drawing with cursor row past the text area")

endmodule

### hdl/tcgr_glyph_mem.sv
// glyph store: 4096 x 8 single write port, registered read port
// uses tcgr_pkg for the address width
module tcgr_glyph_mem (
  input  logic                         clk,
  input  logic                         we,
  input  logic [tcgr_pkg::STORE_AW-1:0] waddr,
  input  logic [7:0]                   wdata,
  input  logic [tcgr_pkg::STORE_AW-1:0] raddr,
  output logic [7:0]                   rdata
);
  import tcgr_pkg::*;

  logic [7:0] mem [0:(1 << STORE_AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### hdl/tcgr_mod_unit.sv
// shared restoring remainder unit, one dividend bit per cycle
// uses tcgr_pkg for the control and status structs
module tcgr_mod_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  tcgr_pkg::mod_ctl_t ctl,
  output tcgr_pkg::mod_sts_t sts
);
  import tcgr_pkg::*;

  localparam int CW = $clog2(MOD_W + 1);

  logic [MOD_W-1:0] rem_r;
  logic [MOD_W-1:0] dvd_r;
  logic [MOD_W-1:0] div_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [MOD_W:0]   trial;
  logic [MOD_W:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[MOD_W-1]};
    rem_nxt = (trial >= {1'b0, div_r}) ? (trial - {1'b0, div_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MOD_W);
        rem_r  <= '0;
        dvd_r  <= ctl.dividend;
        div_r  <= ctl.divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt[MOD_W-1:0];
        dvd_r <= {dvd_r[MOD_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign sts.rem  = rem_r;

endmodule

### tb/testbench.sv
// testbench for the text console glyph renderer: directed and random words under varied idling
// depends on tcgr_pkg and text_console_glyph_renderer_unit
`timescale 1ns / 1ps

module testbench;
  import tcgr_pkg::*;

  localparam int GLYPH_WIDTH       = 8;
  localparam int GLYPH_HEIGHT      = 16;
  localparam int GLYPH_COUNT       = 256;
  localparam int GLYPH_STORE_DEPTH = 1 << STORE_AW;
  localparam int WATCHDOG_LIMIT    = 2000;

  // the fourth kind code is left undefined by the block
  localparam logic [1:0] KIND_UNDEF = 2'd3;

  // one input word as seen on the in_ ports
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  char_code;
    logic [3:0]  fore_index;
    logic [3:0]  back_index;
    logic [11:0] glyph_addr;
    logic [7:0]  glyph_byte;
    logic [9:0]  new_col;
    logic [9:0]  new_row;
  } console_word_t;

  // one result word as seen on the out_ ports
  typedef struct packed {
    logic [1:0]  action;
    logic [20:0] pixel_addr;
    logic [63:0] pixel_bytes;
    logic [8:0]  cursor_col;
    logic [6:0]  cursor_row;
    logic        last;
  } render_result_t;

  // predicts the render results of each accepted word and checks them in order
  class render_scoreboard;
    logic [11:0]    line_pitch;
    logic [8:0]     text_columns;
    logic [6:0]     text_rows;
    logic [63:0]    palette_lo;
    logic [63:0]    palette_hi;
    logic [8:0]     cur_col;
    logic [6:0]     cur_row;
    logic [7:0]     glyph_mem [GLYPH_STORE_DEPTH];
    render_result_t expected_q [$];
    int             errors;

    function new();
      line_pitch   = 12'd800;
      text_columns = 9'd100;
      text_rows    = 7'd30;
      palette_lo   = 64'h0706050403020100;
      palette_hi   = 64'h0F0E0D0C0B0A0908;
      cur_col      = '0;
      cur_row      = '0;
      errors       = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_PITCH:   line_pitch   = data[11:0];
        REG_COLUMNS: text_columns = data[8:0];
        REG_ROWS:    text_rows    = data[6:0];
        REG_PAL_LO:  palette_lo   = data;
        REG_PAL_HI:  palette_hi   = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] colour(logic [3:0] idx);
      logic [63:0] bank;
      bank = idx[3] ? palette_hi : palette_lo;
      return bank[idx[2:0]*8 +: 8];
    endfunction

    // pull the row back onto the last text line, zero rows count as one
    function bit clamp_row();
      logic [6:0] limit;
      limit = (text_rows == 7'd0) ? 7'd1 : text_rows;
      if (cur_row >= limit) begin
        cur_row = limit - 7'd1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void push(logic [1:0] action, logic [20:0] addr, logic [63:0] bytes,
                       logic last);
      render_result_t r;
      r.action      = action;
      r.pixel_addr  = addr;
      r.pixel_bytes = bytes;
      r.cursor_col  = cur_col;
      r.cursor_row  = cur_row;
      r.last        = last;
      expected_q.push_back(r);
    endfunction

    function void note_word(console_word_t w);
      logic [20:0] row_addr [GLYPH_HEIGHT];
      logic [63:0] row_bytes [GLYPH_HEIGHT];
      logic [7:0]  fg;
      logic [7:0]  bg;
      logic [7:0]  bits;
      logic [63:0] lin;
      logic [8:0]  col_limit;
      bit          scroll;
      int          i;
      int          j;
      fg = colour(w.fore_index);
      bg = colour(w.back_index);
      case (w.kind)
        KIND_GLYPH: begin
          glyph_mem[w.glyph_addr] = w.glyph_byte;
          push(ACT_STATUS, '0, '0, 1'b1);
        end
        KIND_CURSOR: begin
          cur_col = 9'(int'(w.new_col) % (int'(text_columns) + 1));
          cur_row = 7'(int'(w.new_row) % (int'(text_rows) + 1));
          push(ACT_STATUS, '0, '0, 1'b1);
        end
        KIND_CHAR: begin
          if (w.char_code == CHAR_NL) begin
            cur_col = '0;
            cur_row = cur_row + 7'd1;
            scroll  = clamp_row();
            push(scroll ? ACT_SCROLL : ACT_STATUS, '0, '0, 1'b1);
          end else if (w.char_code == CHAR_CR) begin
            cur_col = '0;
            push(ACT_STATUS, '0, '0, 1'b1);
          end else begin
            // rows are placed at the cursor as it stands before the advance
            for (i = 0; i < GLYPH_HEIGHT; i++) begin
              bits = glyph_mem[((int'(w.char_code) % GLYPH_COUNT) * GLYPH_HEIGHT + i)
                               % GLYPH_STORE_DEPTH];
              row_bytes[i] = '0;
              for (j = 0; j < GLYPH_WIDTH && j < 8; j++)
                row_bytes[i][8*j +: 8] = bits[j] ? fg : bg;
              lin = (64'(cur_row) * GLYPH_HEIGHT + i) * line_pitch
                    + 64'(cur_col) * GLYPH_WIDTH;
              row_addr[i] = lin[20:0];
            end
            col_limit = (text_columns == 9'd0) ? 9'd1 : text_columns;
            cur_col = cur_col + 9'd1;
            if (cur_col >= col_limit) begin
              cur_col = '0;
              cur_row = cur_row + 7'd1;
            end
            scroll = clamp_row();
            for (i = 0; i < GLYPH_HEIGHT; i++)
              push(ACT_WRITE, row_addr[i], row_bytes[i], !scroll && i == GLYPH_HEIGHT - 1);
            if (scroll)
              push(ACT_SCROLL, '0, '0, 1'b1);
          end
        end
        default: push(ACT_STATUS, '0, '0, 1'b1);
      endcase
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(render_result_t got);
      render_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with nothing pending: action %0d addr 0x%0h",
               got.action, got.pixel_addr);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("action", want.action, got.action);
      compare_field("pixel_addr", want.pixel_addr, got.pixel_addr);
      compare_field("pixel_bytes", want.pixel_bytes, got.pixel_bytes);
      compare_field("cursor_col", want.cursor_col, got.cursor_col);
      compare_field("cursor_row", want.cursor_row, got.cursor_row);
      compare_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // clock, reset and block ports, inputs known from time zero
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_kind = '0;
  logic [7:0]  in_char_code = '0;
  logic [3:0]  in_fore_index = '0;
  logic [3:0]  in_back_index = '0;
  logic [11:0] in_glyph_addr = '0;
  logic [7:0]  in_glyph_byte = '0;
  logic [9:0]  in_new_col = '0;
  logic [9:0]  in_new_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_action;
  logic [20:0] out_pixel_addr;
  logic [63:0] out_pixel_bytes;
  logic [8:0]  out_cursor_col;
  logic [6:0]  out_cursor_row;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  render_scoreboard sb;
  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct = 0;       // chance in a hundred that the receiver stalls a cycle
  int items_sent = 0;
  int idle_cycles = 0;
  int ready_codes [$];     // codes whose sixteen glyph rows are all loaded

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_console_glyph_renderer_unit #(
    .GLYPH_WIDTH (GLYPH_WIDTH),
    .GLYPH_HEIGHT(GLYPH_HEIGHT),
    .GLYPH_COUNT (GLYPH_COUNT)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_char_code   (in_char_code),
    .in_fore_index  (in_fore_index),
    .in_back_index  (in_back_index),
    .in_glyph_addr  (in_glyph_addr),
    .in_glyph_byte  (in_glyph_byte),
    .in_new_col     (in_new_col),
    .in_new_row     (in_new_row),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_action     (out_action),
    .out_pixel_addr (out_pixel_addr),
    .out_pixel_bytes(out_pixel_bytes),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // receiver stall, redrawn every falling edge
  always @(negedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // handshake monitor: values seen here are the ones before the edge
  always @(posedge clk) begin : monitor
    console_word_t  w;
    render_result_t r;
    if (rst_n) begin
      // results first, a word never yields a result at its own accept edge
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        r.action      = out_action;
        r.pixel_addr  = out_pixel_addr;
        r.pixel_bytes = out_pixel_bytes;
        r.cursor_col  = out_cursor_col;
        r.cursor_row  = out_cursor_row;
        r.last        = out_last;
        sb.check_result(r);
      end
      if (in_valid && in_stall === 1'b0) begin
        w.kind       = in_kind;
        w.char_code  = in_char_code;
        w.fore_index = in_fore_index;
        w.back_index = in_back_index;
        w.glyph_addr = in_glyph_addr;
        w.glyph_byte = in_glyph_byte;
        w.new_col    = in_new_col;
        w.new_row    = in_new_row;
        sb.note_word(w);
      end
      if (cfg_valid && cfg_ready === 1'b1)
        sb.write_reg(cfg_index, cfg_data);
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0) ||
          (cfg_valid && cfg_ready === 1'b1))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // random content in every field, kind fixed by the caller
  function automatic console_word_t noise_word(logic [1:0] kind);
    console_word_t w;
    w.kind       = kind;
    w.char_code  = 8'($urandom);
    w.fore_index = 4'($urandom);
    w.back_index = 4'($urandom);
    w.glyph_addr = 12'($urandom);
    w.glyph_byte = 8'($urandom);
    w.new_col    = 10'($urandom);
    w.new_row    = 10'($urandom);
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_word(console_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= w.kind;
    in_char_code  <= w.char_code;
    in_fore_index <= w.fore_index;
    in_back_index <= w.back_index;
    in_glyph_addr <= w.glyph_addr;
    in_glyph_byte <= w.glyph_byte;
    in_new_col    <= w.new_col;
    in_new_row    <= w.new_row;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_char(logic [7:0] code);
    console_word_t w;
    w = noise_word(KIND_CHAR);
    w.char_code = code;
    send_word(w);
  endtask

  task automatic send_cursor(logic [9:0] col, logic [9:0] row);
    console_word_t w;
    w = noise_word(KIND_CURSOR);
    w.new_col = col;
    w.new_row = row;
    send_word(w);
  endtask

  // all sixteen rows of one glyph, blank and solid rows now and then
  task automatic load_glyph(int code);
    console_word_t w;
    int i;
    for (i = 0; i < GLYPH_HEIGHT; i++) begin
      w = noise_word(KIND_GLYPH);
      w.glyph_addr = 12'(code * GLYPH_HEIGHT + i);
      case ($urandom_range(7))
        0: w.glyph_byte = 8'h00;
        1: w.glyph_byte = 8'hFF;
        default: ;
      endcase
      send_word(w);
    end
    foreach (ready_codes[k])
      if (ready_codes[k] == code) return;
    ready_codes.push_back(code);
  endtask

  // sender holds off until every pending result word is out
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // all five registers back to back, block idle
  task automatic configure(logic [11:0] pitch, logic [8:0] cols, logic [6:0] rows,
                           logic [63:0] pal_lo, logic [63:0] pal_hi);
    logic [2:0]  idx [5];
    logic [63:0] val [5];
    int k;
    idx = '{REG_PITCH, REG_COLUMNS, REG_ROWS, REG_PAL_LO, REG_PAL_HI};
    val = '{64'(pitch), 64'(cols), 64'(rows), pal_lo, pal_hi};
    for (k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly glyph loads followed by text, the rest control and noise words
  task automatic random_traffic(int count);
    int  stop;
    int  half;
    int  pick;
    int  code;
    bit  paused;
    stop   = items_sent + count;
    half   = items_sent + count / 2;
    paused = 1'b0;
    while (items_sent < stop) begin
      if (!paused && items_sent >= half) begin
        paused = 1'b1;
        drain();
      end
      pick = $urandom_range(99);
      if (pick < 14) begin
        case ($urandom_range(9))
          0: code = 0;
          1: code = 255;
          default: code = $urandom_range(255);
        endcase
        load_glyph(code);
      end else if (pick < 58) begin
        repeat ($urandom_range(4, 1))
          send_char(8'(ready_codes[$urandom_range(ready_codes.size() - 1)]));
      end else if (pick < 68) begin
        send_char(CHAR_NL);
      end else if (pick < 73) begin
        send_char(CHAR_CR);
      end else if (pick < 85) begin
        // a third of these land just outside the text area
        if ($urandom_range(2) == 0)
          send_cursor(10'(sb.text_columns), 10'(sb.text_rows));
        else
          send_cursor(10'($urandom), 10'($urandom));
      end else if (pick < 90) begin
        send_word(noise_word(KIND_UNDEF));
      end else begin
        // stray glyph byte anywhere in the store
        send_word(noise_word(KIND_GLYPH));
      end
    end
  endtask

  task automatic run_phase(logic [11:0] pitch, logic [8:0] cols, logic [6:0] rows,
                           logic [63:0] pal_lo, logic [63:0] pal_hi,
                           int send_pct, int recv_pct, int count);
    drain();
    configure(pitch, cols, rows, pal_lo, pal_hi);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    random_traffic(count);
  endtask

  initial begin
    console_word_t w;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed words under the reset register values, no idling
    send_word(noise_word(KIND_UNDEF));
    load_glyph(255);
    w = noise_word(KIND_CHAR);
    w.char_code  = 8'hFF;
    w.fore_index = 4'hF;
    w.back_index = 4'h0;
    send_word(w);
    w.fore_index = 4'h0;
    w.back_index = 4'hF;
    send_word(w);
    send_char(CHAR_CR);
    send_char(CHAR_NL);
    send_cursor(10'd1023, 10'd1023);
    // cursor just past the text area, drawn there then wrapped and scrolled
    send_cursor(10'd100, 10'd30);
    send_char(8'hFF);
    // wrap off the end of the last line
    send_cursor(10'd99, 10'd29);
    send_char(8'hFF);
    // newline on the last line scrolls
    send_cursor(10'd0, 10'd29);
    send_char(CHAR_NL);

    // random phases over register settings and idling patterns
    run_phase(12'd800, 9'd100, 7'd30, {$urandom, $urandom}, {$urandom, $urandom},
              0, 0, 55);
    run_phase(12'd8, 9'd1, 7'd1, {$urandom, $urandom}, {$urandom, $urandom},
              57, 0, 55);
    run_phase(12'd2048, 9'd256, 7'd64, '1, '0, 0, 57, 65);
    // zero columns and rows act as one for wrap and scroll
    run_phase(12'd2048, 9'd0, 7'd0, '0, '1, 29, 29, 45);
    run_phase(12'($urandom_range(2048, 8)), 9'($urandom_range(256, 1)),
              7'($urandom_range(64, 1)), {$urandom, $urandom}, {$urandom, $urandom},
              29, 29, 70);
    run_phase(12'd640, 9'd80, 7'd25, {$urandom, $urandom}, {$urandom, $urandom},
              57, 0, 60);
    run_phase(12'($urandom_range(2048, 8)), 9'($urandom_range(256, 1)),
              7'($urandom_range(64, 1)), {$urandom, $urandom}, {$urandom, $urandom},
              0, 57, 55);
    run_phase(12'($urandom_range(2048, 8)), 9'($urandom_range(256, 1)),
              7'($urandom_range(64, 1)), {$urandom, $urandom}, {$urandom, $urandom},
              0, 0, 30);

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
